/* src/vnd_pkg.sv */
// ----------------------------------------------------------------------------
// vnd_pkg
// Shared widths, mode codes and status types of the vector distance block.
// ----------------------------------------------------------------------------
`default_nettype none

package vnd_pkg;

  localparam int ACC_W  = 48;
  localparam int DIST_W = 27;
  localparam int MODE_W = 2;

  localparam int MAX_LEN_DEF   = 1024;
  localparam int ELEM_BITS_DEF = 16;

  localparam logic [ACC_W-1:0]  ACC_MAX  = {ACC_W{1'b1}};
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // distance kinds, bit one set selects the running maximum
  localparam logic [MODE_W-1:0] MODE_L1   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_L2   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LINF = 2'd2;
  localparam int                MODE_MAX_BIT = 1;

  localparam logic [MODE_W-1:0] MODE_RESET = MODE_L2;

  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

endpackage

`default_nettype wire

/* src/vnd_in_if.sv */
// ----------------------------------------------------------------------------
// vnd_in_if
// Element pair channel: two signed elements and the last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface vnd_in_if #(
  parameter int ELEM_BITS = vnd_pkg::ELEM_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [ELEM_BITS-1:0] elem_a;
  logic signed [ELEM_BITS-1:0] elem_b;
  logic                        last;

  modport source (output valid, output elem_a, output elem_b, output last, input ready);
  modport sink   (input valid, input elem_a, input elem_b, input last, output ready);
endinterface

`default_nettype wire

/* src/vnd_out_if.sv */
// ----------------------------------------------------------------------------
// vnd_out_if
// Result channel: distance and the too-long flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface vnd_out_if;
  logic                        valid;
  logic                        ready;
  logic [vnd_pkg::DIST_W-1:0]  distance;
  logic                        too_long;

  modport source (output valid, output distance, output too_long, input ready);
  modport sink   (input valid, input distance, input too_long, output ready);
endinterface

`default_nettype wire

/* src/vnd_sqrt.sv */
// ----------------------------------------------------------------------------
// vnd_sqrt
// Iterative floor square root, one root bit per cycle (digit recurrence).
// ----------------------------------------------------------------------------
`default_nettype none

module vnd_sqrt (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [vnd_pkg::ACC_W-1:0] operand_i,
  output vnd_pkg::sqrt_stat_t            stat_o,
  output logic [vnd_pkg::ACC_W/2-1:0]    root_o
);

  localparam int ACC_W  = vnd_pkg::ACC_W;
  localparam int ROOT_W = ACC_W / 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int CNT_W  = $clog2(ROOT_W);

  logic [ACC_W-1:0]  n_q,    n_d;
  logic [REM_W-1:0]  rem_q,  rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [CNT_W-1:0]  cnt_q,  cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;

  logic [REM_W-1:0]  rem_shift;
  logic [REM_W-1:0]  trial;

  always_comb begin
    rem_shift = {rem_q[REM_W-3:0], n_q[ACC_W-1 -: 2]};
    trial     = {root_q, 2'b01};
    n_d       = n_q;
    rem_d     = rem_q;
    root_d    = root_q;
    cnt_d     = cnt_q;
    busy_d    = busy_q;
    done_d    = 1'b0;
    if (start_i) begin
      n_d    = operand_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CNT_W'(ROOT_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      n_d = {n_q[ACC_W-3:0], 2'b00};
      if (rem_shift >= trial) begin
        rem_d  = rem_shift - trial;
        root_d = {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_shift;
        root_d = {root_q[ROOT_W-2:0], 1'b0};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign root_o      = root_q;

endmodule

`default_nettype wire

/* src/vector_norm_distance.sv */
// ----------------------------------------------------------------------------
// vector_norm_distance
// L1 / L2 / Linf distance between two vectors streamed one pair per beat.
// ----------------------------------------------------------------------------
// One element pair is taken per input beat; the block then drops ready while
// a small sequencer forms the magnitude (and its square for L2) in ST_MAG
// and folds it into the 48-bit saturating accumulator in ST_ACC. A pair
// with last then goes to ST_FINISH, which loads the result register; in L2
// mode the square-root unit first resolves one root bit per cycle in
// ST_ROOT, 24 root bits in all, before ST_FINISH. The result waits in an
// output register, so the next vector may start while the previous
// distance is still not taken. The mode register (reset L2) is sampled
// with each pair; a vector over MAX_LEN pairs gives too_long with the
// distance saturated.
`default_nettype none

module vector_norm_distance #(
  parameter int MAX_LEN   = vnd_pkg::MAX_LEN_DEF,
  parameter int ELEM_BITS = vnd_pkg::ELEM_BITS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [vnd_pkg::MODE_W-1:0] cfg_wdata_i,
  vnd_in_if.sink                          in_i,
  vnd_out_if.source                       out_o
);

  localparam int ACC_W  = vnd_pkg::ACC_W;
  localparam int DIST_W = vnd_pkg::DIST_W;
  localparam int MODE_W = vnd_pkg::MODE_W;
  localparam int ROOT_W = ACC_W / 2;
  localparam int MAG_W  = ELEM_BITS + 1;
  localparam int TERM_W = 2 * MAG_W;
  localparam int SUM_W  = ((TERM_W > ACC_W) ? TERM_W : ACC_W) + 1;
  localparam int CNT_W  = $clog2(MAX_LEN + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAG,
    ST_ACC,
    ST_ROOT,
    ST_FINISH
  } state_e;

  state_e                      state_q, state_d;
  logic [MODE_W-1:0]           mode_q, mode_d;
  logic [MODE_W-1:0]           item_mode_q, item_mode_d;
  logic signed [ELEM_BITS-1:0] a_q, a_d, b_q, b_d;
  logic                        last_q, last_d;
  logic [TERM_W-1:0]           term_q, term_d;
  logic [ACC_W-1:0]            acc_q, acc_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic                        ovf_q, ovf_d;
  logic                        out_valid_q, out_valid_d;
  logic [DIST_W-1:0]           dist_q, dist_d;
  logic                        too_long_q, too_long_d;

  logic signed [MAG_W-1:0]     diff;
  logic [MAG_W-1:0]            mag;
  logic [SUM_W-1:0]            sum;
  logic [ACC_W-1:0]            final_val;
  logic                        sqrt_start;
  vnd_pkg::sqrt_stat_t         sqrt_stat;
  logic [ROOT_W-1:0]           sqrt_root;

  vnd_sqrt u_sqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (sqrt_start),
    .operand_i (acc_d),
    .stat_o    (sqrt_stat),
    .root_o    (sqrt_root)
  );

  always_comb begin
    diff = MAG_W'(a_q) - MAG_W'(b_q);
    mag  = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
    sum  = SUM_W'(acc_q) + SUM_W'(term_q);

    if (ovf_q) begin
      final_val = ACC_W'(vnd_pkg::DIST_MAX);
    end else if (item_mode_q == vnd_pkg::MODE_L2) begin
      final_val = ACC_W'(sqrt_root);
    end else begin
      final_val = acc_q;
    end

    state_d     = state_q;
    mode_d      = cfg_we_i ? cfg_wdata_i : mode_q;
    item_mode_d = item_mode_q;
    a_d         = a_q;
    b_d         = b_q;
    last_d      = last_q;
    term_d      = term_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && !out_o.ready;
    dist_d      = dist_q;
    too_long_d  = too_long_q;
    sqrt_start  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          a_d         = in_i.elem_a;
          b_d         = in_i.elem_b;
          last_d      = in_i.last;
          item_mode_d = mode_q;
          state_d     = ST_MAG;
        end
      end
      ST_MAG: begin
        if (item_mode_q == vnd_pkg::MODE_L2) begin
          term_d = TERM_W'(mag) * TERM_W'(mag);
        end else begin
          term_d = TERM_W'(mag);
        end
        state_d = ST_ACC;
      end
      ST_ACC: begin
        if (cnt_q >= CNT_W'(MAX_LEN)) begin
          ovf_d = 1'b1;
        end else begin
          cnt_d = cnt_q + 1'b1;
          if (item_mode_q[vnd_pkg::MODE_MAX_BIT]) begin
            if (SUM_W'(term_q) > SUM_W'(acc_q)) begin
              acc_d = ACC_W'(term_q);
            end
          end else if (sum > SUM_W'(vnd_pkg::ACC_MAX)) begin
            acc_d = vnd_pkg::ACC_MAX;
          end else begin
            acc_d = ACC_W'(sum);
          end
        end
        if (!last_q) begin
          state_d = ST_IDLE;
        end else if (item_mode_q == vnd_pkg::MODE_L2 && !ovf_d) begin
          sqrt_start = 1'b1;
          state_d    = ST_ROOT;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_ROOT: begin
        if (sqrt_stat.done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          too_long_d  = ovf_q;
          if (final_val > ACC_W'(vnd_pkg::DIST_MAX)) begin
            dist_d = vnd_pkg::DIST_MAX;
          end else begin
            dist_d = DIST_W'(final_val);
          end
          acc_d   = '0;
          cnt_d   = '0;
          ovf_d   = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= vnd_pkg::MODE_RESET;
      item_mode_q <= vnd_pkg::MODE_RESET;
      last_q      <= 1'b0;
      acc_q       <= '0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      too_long_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      item_mode_q <= item_mode_d;
      last_q      <= last_d;
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      too_long_q  <= too_long_d;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    term_q <= term_d;
    dist_q <= dist_d;
  end

  assign in_i.ready     = (state_q == ST_IDLE);
  assign out_o.valid    = out_valid_q;
  assign out_o.distance = dist_q;
  assign out_o.too_long = too_long_q;

endmodule

`default_nettype wire

/* src/vnd_checker.sv */
// ----------------------------------------------------------------------------
// vnd_checker
// Port-level checks of the vector distance block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module vnd_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_ready_i,
  input wire logic                       in_last_i,
  input wire logic                       out_valid_i,
  input wire logic                       out_ready_i,
  input wire logic [vnd_pkg::DIST_W-1:0] distance_i,
  input wire logic                       too_long_i
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(distance_i) && $stable(too_long_i))
    else $error("result beat changed while stalled");

  // the sequencer is busy right after taking a pair
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("ready high right after an accepted beat");

  // a pair without last is folded in, then ready returns once ST_MAG and ST_ACC are done
  a_plain_return: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !in_last_i |-> ##3 in_ready_i)
    else $error("ready did not return after a plain pair");

  // too long vectors report a saturated distance
  a_too_long_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && too_long_i |-> distance_i == vnd_pkg::DIST_MAX)
    else $error("too_long without saturated distance");

endmodule

bind vector_norm_distance vnd_checker u_vnd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.last),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .distance_i  (out_o.distance),
  .too_long_i  (out_o.too_long)
);

`default_nettype wire

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Streams signed element pairs into the vector distance block under every
// distance kind, including over-length vectors and mode changes inside a
// vector. Each distance beat is checked against an in-bench prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int ACC_W          = vnd_pkg::ACC_W;
  localparam int DIST_W         = vnd_pkg::DIST_W;
  localparam int MODE_W         = vnd_pkg::MODE_W;
  localparam int MAX_LEN        = vnd_pkg::MAX_LEN_DEF;
  localparam int ELEM_BITS      = vnd_pkg::ELEM_BITS_DEF;
  localparam int SETTLE_CYCLES  = 40;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;

  // bit one set selects the maximum, so code three behaves as Linf
  localparam logic [MODE_W-1:0] MODE_LINF_ALT = 2'd3;

  localparam logic signed [ELEM_BITS-1:0] ELEM_MAX = {1'b0, {(ELEM_BITS-1){1'b1}}};
  localparam logic signed [ELEM_BITS-1:0] ELEM_MIN = {1'b1, {(ELEM_BITS-1){1'b0}}};

  typedef struct packed {
    logic signed [ELEM_BITS-1:0] a;
    logic signed [ELEM_BITS-1:0] b;
    logic                        last;
  } pair_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              too_long;
  } dist_t;

  typedef enum {RX_STEADY, RX_RANDOM, RX_PATTERN} rx_style_e;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [MODE_W-1:0] cfg_wdata_i;

  vnd_in_if #(.ELEM_BITS(ELEM_BITS)) in_if ();
  vnd_out_if                         out_if ();

  vector_norm_distance #(
    .MAX_LEN  (MAX_LEN),
    .ELEM_BITS(ELEM_BITS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // prediction state
  logic [MODE_W-1:0] pred_mode;
  logic [ACC_W-1:0]  pred_acc;
  int                pred_count;
  logic              pred_over;
  dist_t             pending_dists[$];

  int          err_count;
  int          hold_left;
  rx_style_e   rx_style;
  logic [15:0] rx_pattern;
  logic        tx_gaps_on;
  int          burst_left;
  logic        offering;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [ACC_W-1:0] isqrt(input logic [ACC_W-1:0] n);
    logic [ACC_W-1:0] root;
    logic [ACC_W-1:0] trial;
    int               i;
    root = '0;
    for (i = ACC_W/2 - 1; i >= 0; i--) begin
      trial = root | (ACC_W'(1) << i);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  task automatic accumulate_pair(input pair_t p);
    logic signed [ELEM_BITS:0] diff;
    logic [ELEM_BITS:0]        mag;
    logic [ACC_W:0]            sum;
    logic [ACC_W-1:0]          full;
    dist_t                     res;
    diff = {p.a[ELEM_BITS-1], p.a} - {p.b[ELEM_BITS-1], p.b};
    mag  = diff[ELEM_BITS] ? -diff : diff;
    if (pred_count >= MAX_LEN) begin
      pred_over = 1'b1;
    end else begin
      pred_count++;
      if (pred_mode[vnd_pkg::MODE_MAX_BIT]) begin
        if (ACC_W'(mag) > pred_acc) pred_acc = ACC_W'(mag);
      end else begin
        if (pred_mode == vnd_pkg::MODE_L2)
          sum = (ACC_W+1)'(pred_acc) + (ACC_W+1)'(mag) * (ACC_W+1)'(mag);
        else
          sum = (ACC_W+1)'(pred_acc) + (ACC_W+1)'(mag);
        pred_acc = sum[ACC_W] ? vnd_pkg::ACC_MAX : sum[ACC_W-1:0];
      end
    end
    if (p.last) begin
      if (pred_over) begin
        res.distance = vnd_pkg::DIST_MAX;
      end else begin
        full = (pred_mode == vnd_pkg::MODE_L2) ? isqrt(pred_acc) : pred_acc;
        res.distance = (full > ACC_W'(vnd_pkg::DIST_MAX)) ? vnd_pkg::DIST_MAX
                                                          : full[DIST_W-1:0];
      end
      res.too_long = pred_over;
      pending_dists.push_back(res);
      pred_acc   = '0;
      pred_count = 0;
      pred_over  = 1'b0;
    end
  endtask

  task automatic send_pair(input pair_t p);
    in_if.valid  <= 1'b1;
    in_if.elem_a <= p.a;
    in_if.elem_b <= p.b;
    in_if.last   <= p.last;
    offering = 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    accumulate_pair(p);
    if (tx_gaps_on) begin
      if (burst_left == 0) begin
        in_if.valid <= 1'b0;
        offering = 1'b0;
        repeat ($urandom_range(8, 1)) @(posedge clk_i);
        burst_left = $urandom_range(24, 1);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic stop_sending();
    if (offering) begin
      in_if.valid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  task automatic wait_results(input int settle);
    stop_sending();
    do @(posedge clk_i); while (pending_dists.size() != 0);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic [MODE_W-1:0] mode);
    wait_results(SETTLE_CYCLES);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pred_mode = mode;
  endtask

  function automatic logic signed [ELEM_BITS-1:0] rand_elem();
    case ($urandom_range(9))
      0:       return ELEM_MAX;
      1:       return ELEM_MIN;
      2, 3:    return ELEM_BITS'(int'($urandom_range(16)) - 8);
      default: return ELEM_BITS'($urandom());
    endcase
  endfunction

  task automatic send_vector(input int len);
    pair_t p;
    int    i;
    for (i = 0; i < len; i++) begin
      p.a    = rand_elem();
      p.b    = rand_elem();
      p.last = (i == len - 1);
      send_pair(p);
    end
  endtask

  // no write yet: the block must come out of reset in L2
  task automatic test_reset_mode();
    send_pair(pair_t'{ELEM_MAX, ELEM_MIN, 1'b1});
    send_pair(pair_t'{16'sd3, -16'sd1, 1'b0});
    send_pair(pair_t'{16'sd0, 16'sd3, 1'b1});
    wait_results(SETTLE_CYCLES);
  endtask

  task automatic test_distance_kinds();
    logic [MODE_W-1:0] modes[4];
    int                m;
    modes = '{vnd_pkg::MODE_L1, vnd_pkg::MODE_L2, vnd_pkg::MODE_LINF, MODE_LINF_ALT};
    for (m = 0; m < 4; m++) begin
      write_mode(modes[m]);
      send_pair(pair_t'{ELEM_MAX, ELEM_MIN, 1'b0});
      send_pair(pair_t'{ELEM_MIN, ELEM_MAX, 1'b0});
      send_pair(pair_t'{-16'sd1, 16'sd0, 1'b0});
      send_pair(pair_t'{16'sd0, 16'sd0, 1'b1});
      send_pair(pair_t'{16'sd0, 16'sd0, 1'b1});
    end
    wait_results(SETTLE_CYCLES);
  endtask

  // earlier pairs keep the kind they were folded under, the last one decides the root
  task automatic test_mode_switch_mid_vector();
    write_mode(vnd_pkg::MODE_L1);
    send_pair(pair_t'{16'sd100, -16'sd100, 1'b0});
    send_pair(pair_t'{-16'sd5, 16'sd7, 1'b0});
    write_mode(vnd_pkg::MODE_L2);
    send_pair(pair_t'{16'sd3, 16'sd0, 1'b1});
    write_mode(vnd_pkg::MODE_LINF);
    send_pair(pair_t'{16'sd1000, 16'sd0, 1'b0});
    write_mode(vnd_pkg::MODE_L1);
    send_pair(pair_t'{16'sd1, 16'sd0, 1'b1});
    wait_results(SETTLE_CYCLES);
  endtask

  // one pair past the limit, then a short vector to see the state cleared
  task automatic test_overlength();
    tx_gaps_on = 1'b0;
    rx_style   = RX_STEADY;
    write_mode(vnd_pkg::MODE_L2);
    send_vector(MAX_LEN + 1);
    send_vector(2);
    wait_results(SETTLE_CYCLES);
  endtask

  // long receiver hold-off so the result register fills and the input stalls
  task automatic test_output_backpressure();
    tx_gaps_on = 1'b0;
    rx_style   = RX_STEADY;
    write_mode(vnd_pkg::MODE_L2);
    hold_left = HOLD_CYCLES;
    repeat (8) send_vector($urandom_range(3, 1));
    wait_results(1);
    send_vector(4);
    wait_results(SETTLE_CYCLES);
  endtask

  task automatic test_random_vectors();
    int phase;
    int sent;
    int len;
    for (phase = 0; phase < 7; phase++) begin
      case (phase)
        0:       write_mode(vnd_pkg::MODE_L1);
        1:       write_mode(MODE_LINF_ALT);
        default: write_mode(MODE_W'($urandom_range(3)));
      endcase
      tx_gaps_on = (phase != 2);
      rx_pattern = 16'($urandom()) | 16'h0101;
      rx_style   = (phase == 2) ? RX_STEADY : rx_style_e'($urandom_range(2));
      sent = 0;
      while (sent < 40) begin
        len = ($urandom_range(19) == 0) ? $urandom_range(60, 13) : $urandom_range(12, 1);
        send_vector(len);
        sent += len;
        if ($urandom_range(9) == 0) wait_results(1);
      end
    end
    wait_results(SETTLE_CYCLES);
  endtask

  // receiver: long hold-off on request, otherwise steady, random or patterned stalls
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        case (rx_style)
          RX_STEADY: out_if.ready <= 1'b1;
          RX_RANDOM: out_if.ready <= ($urandom_range(99) < 70);
          default: begin
            out_if.ready <= rx_pattern[0];
            rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
          end
        endcase
      end
    end
  end

  initial begin : result_check
    dist_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        if (pending_dists.size() == 0) begin
          $error("distance beat with no vector pending: distance %0d too_long %0b",
                 out_if.distance, out_if.too_long);
          err_count++;
        end else begin
          want = pending_dists.pop_front();
          if (out_if.distance !== want.distance) begin
            $error("distance: expected %0d, got %0d", want.distance, out_if.distance);
            err_count++;
          end
          if (out_if.too_long !== want.too_long) begin
            $error("too_long: expected %0b, got %0b", want.too_long, out_if.too_long);
            err_count++;
          end
        end
      end
    end
  end

  // watchdog on cycles without any beat on either channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = vnd_pkg::MODE_RESET;
    in_if.valid  = 1'b0;
    in_if.elem_a = '0;
    in_if.elem_b = '0;
    in_if.last   = 1'b0;
    pred_mode    = vnd_pkg::MODE_RESET;
    pred_acc     = '0;
    pred_count   = 0;
    pred_over    = 1'b0;
    err_count    = 0;
    hold_left    = 0;
    rx_style     = RX_RANDOM;
    rx_pattern   = 16'b1011_0111_0011_1101;
    tx_gaps_on   = 1'b1;
    burst_left   = 5;
    offering     = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_mode();
    test_distance_kinds();
    test_mode_switch_mid_vector();
    test_overlength();
    test_output_backpressure();
    test_random_vectors();

    wait_results(SETTLE_CYCLES);
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

/* vector_norm_distance.f */
src/vnd_pkg.sv
src/vnd_in_if.sv
src/vnd_out_if.sv
src/vnd_sqrt.sv
src/vector_norm_distance.sv
src/vnd_checker.sv
sim/testbench.sv
